>>> src/agent_vertex_swap_conflict_detect_assert.svh
// ----------------------------------------------------------------------------
// agent vertex swap conflict detect: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef AGENT_VERTEX_SWAP_CONFLICT_DETECT_ASSERT_SVH
`define AGENT_VERTEX_SWAP_CONFLICT_DETECT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define AVSCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avscd assertion failed");

// consequent must hold in the cycle after the antecedent
`define AVSCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avscd assertion failed");

`endif

>>> src/avscd_pkg.sv
// ----------------------------------------------------------------------------
// avscd_pkg
// Types and constants shared by the agent conflict detector modules.
// ----------------------------------------------------------------------------
package avscd_pkg;

    // default sizing
    localparam int MAX_AGENTS_DEF = 8;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int ID_W  = 16;
    localparam int IO_W  = 16;
    localparam int TS_W  = 16;

    // one path cell item
    typedef struct packed {
        logic [ID_W-1:0]        agent_id;
        logic signed [IO_W-1:0] cell_x;
        logic signed [IO_W-1:0] cell_y;
        logic signed [IO_W-1:0] cell_z;
        logic                   path_empty;
        logic                   end_of_path;
        logic                   end_of_set;
    } t_in_item;

    // one result item: conflict record or end marker
    typedef struct packed {
        logic                   is_record;
        logic [ID_W-1:0]        agent_a;
        logic [ID_W-1:0]        agent_b;
        logic                   is_edge;
        logic signed [IO_W-1:0] here_x;
        logic signed [IO_W-1:0] here_y;
        logic signed [IO_W-1:0] here_z;
        logic signed [IO_W-1:0] before_x;
        logic signed [IO_W-1:0] before_y;
        logic signed [IO_W-1:0] before_z;
        logic                   overflow;
        logic                   last;
    } t_out_item;

    // configuration write
    typedef struct packed {
        logic [TS_W-1:0] time_step;
    } t_cfg_item;

    // chain operation broadcast to every cell
    typedef struct packed {
        logic load;    // append a finished agent at the fill position
        logic pop;     // shift the whole chain one place toward the head
        logic rotate;  // rotate the occupied part of the chain by one place
    } t_chain_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_POP,
        ST_CMP,
        ST_MARK
    } t_state;

endpackage

>>> src/avscd_chan_if.sv
// ----------------------------------------------------------------------------
// avscd_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface avscd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/avscd_capture.sv
// ----------------------------------------------------------------------------
// avscd_capture
// Tracks the path of the streaming agent and picks out its cell at the
// observed time step and at the step before.
// ----------------------------------------------------------------------------
module avscd_capture #(
    parameter int COORD_BITS = avscd_pkg::COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  avscd_pkg::t_in_item       i_item,
    input  logic [avscd_pkg::TS_W-1:0] i_time_step,
    output logic                      o_done,
    output logic [3*COORD_BITS-1:0]   o_now,
    output logic [3*COORD_BITS-1:0]   o_prev
);
    import avscd_pkg::*;

    localparam int CW = 3 * COORD_BITS;

    logic [TS_W-1:0] r_pos, n_pos;
    logic            r_now_vld, r_prev_vld;
    logic [CW-1:0]   r_first, r_cap_now, r_cap_prev;
    logic [CW-1:0]   w_cell, w_first;
    logic            w_hit_now, w_hit_prev, w_first_pos;

    // coordinates sign-extended or cut to the internal width
    assign w_cell = {COORD_BITS'(i_item.cell_x), COORD_BITS'(i_item.cell_y),
                     COORD_BITS'(i_item.cell_z)};

    // capture hits for this cell
    assign w_first_pos = (r_pos == '0);
    assign w_hit_now   = !r_now_vld && (r_pos == i_time_step);
    assign w_hit_prev  = (i_time_step != '0) && !r_prev_vld
                         && (r_pos == i_time_step - TS_W'(1));
    assign w_first     = w_first_pos ? w_cell : r_first;
    assign n_pos       = (r_pos == '1) ? r_pos : r_pos + TS_W'(1);

    // finished agent cells
    assign o_done = i_item.path_empty | i_item.end_of_path | i_item.end_of_set;
    always_comb begin
        if (i_item.path_empty) begin
            o_now  = '0;
            o_prev = '0;
        end else begin
            o_now = r_now_vld ? r_cap_now : w_cell;
            if (i_time_step == '0) begin
                o_prev = w_first;
            end else begin
                o_prev = r_prev_vld ? r_cap_prev : w_cell;
            end
        end
    end

    // path position and capture flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_now_vld  <= 1'b0;
            r_prev_vld <= 1'b0;
        end else if (i_accept) begin
            if (o_done) begin
                r_pos      <= '0;
                r_now_vld  <= 1'b0;
                r_prev_vld <= 1'b0;
            end else begin
                r_pos <= n_pos;
                if (w_hit_now) begin
                    r_now_vld <= 1'b1;
                end
                if (w_hit_prev) begin
                    r_prev_vld <= 1'b1;
                end
            end
        end
    end

    // captured cells
    always_ff @(posedge i_clk) begin
        if (i_accept && !i_item.path_empty) begin
            if (w_first_pos) begin
                r_first <= w_cell;
            end
            if (w_hit_now) begin
                r_cap_now <= w_cell;
            end
            if (w_hit_prev) begin
                r_cap_prev <= w_cell;
            end
        end
    end

endmodule

>>> src/avscd_cell.sv
// ----------------------------------------------------------------------------
// avscd_cell
// One place of the agent chain: holds an agent's id and cells, and takes
// a new agent, its neighbor's entry or the head entry as the op says.
// ----------------------------------------------------------------------------
module avscd_cell #(
    parameter int DATA_W = 112,
    parameter int CNT_W  = 4,
    parameter int POS    = 0,
    parameter int LAST   = 7
) (
    input  logic                 i_clk,
    input  avscd_pkg::t_chain_op i_op,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [DATA_W-1:0]    i_load_data,
    input  logic [DATA_W-1:0]    i_next_data,
    input  logic [DATA_W-1:0]    i_head_data,
    output logic [DATA_W-1:0]    o_data
);
    import avscd_pkg::*;

    localparam logic [CNT_W-1:0] K = CNT_W'(POS);
    localparam bit HasNext = (POS < LAST);

    logic [DATA_W-1:0] r_data;
    logic [CNT_W-1:0]  w_tail;
    logic              w_load, w_next, w_head;

    // decode this place's move
    assign w_tail = i_count - CNT_W'(1);
    assign w_load = i_op.load && (i_count == K);
    assign w_head = i_op.rotate && (K == w_tail);
    assign w_next = HasNext && (i_op.pop || (i_op.rotate && (K < w_tail)));

    // entry register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_load_data;
        end else if (w_head) begin
            r_data <= i_head_data;
        end else if (w_next) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

>>> src/agent_vertex_swap_conflict_detect.sv
// ----------------------------------------------------------------------------
// agent_vertex_swap_conflict_detect
// Collects agent paths into a chain of cells and sweeps all agent pairs
// for vertex and swap conflicts at the observed time step.
// ----------------------------------------------------------------------------
//  channel  | dir | payload      | handshake
//  i_in     | in  | t_in_item    | valid/ready, one path cell per item
//  o_out    | out | t_out_item   | valid/ready, records then end marker
//  i_cfg    | in  | t_cfg_item   | valid/ready, always ready, time_step
//
//  Path cells are taken whenever the sequencer collects. After the set's
//  last item the stored agents are swept, one agent pair per cycle as the
//  chain rotates past the probe register; input is held off meanwhile. A
//  stalled output register holds the sweep on a conflicting pair and
//  holds back the end marker.
//  Reset clears the sequencer, counts and capture flags; stored entries have
//  no reset and are only read below the agent count.
// ----------------------------------------------------------------------------
module agent_vertex_swap_conflict_detect #(
    parameter int MAX_AGENTS = avscd_pkg::MAX_AGENTS_DEF,
    parameter int COORD_BITS = avscd_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    avscd_chan_if.sink          i_in,
    avscd_chan_if.source        o_out,
    avscd_chan_if.sink          i_cfg
);
    import avscd_pkg::*;

    localparam int CW     = 3 * COORD_BITS;
    localparam int DATA_W = ID_W + 2 * CW;
    localparam int CNT_W  = $clog2(MAX_AGENTS + 1);

    t_state             r_state, n_state;
    logic [TS_W-1:0]    r_time_step;
    logic [CNT_W-1:0]   r_count, r_j;
    logic               r_dropped;
    logic [DATA_W-1:0]  r_probe;
    t_out_item          r_out;
    logic               r_out_valid;

    t_chain_op          w_op;
    logic               w_in_ready, w_in_acc;
    logic               w_probe_ld, w_out_ld, w_mark_ld, w_out_free;
    logic               w_done;
    logic [CW-1:0]      w_cap_now, w_cap_prev;
    logic [DATA_W-1:0]  w_cell_q [MAX_AGENTS];
    logic [DATA_W-1:0]  w_load_data;
    logic [ID_W-1:0]    w_pr_id, w_hd_id;
    logic [CW-1:0]      w_pr_now, w_pr_prev, w_hd_now, w_hd_prev;
    logic               w_vertex, w_edge, w_hit;
    t_out_item          w_rec, w_mark;

    // configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= '0;
        end else if (i_cfg.valid) begin
            r_time_step <= i_cfg.payload.time_step;
        end
    end

    // path capture for the streaming agent
    assign w_in_acc = i_in.valid && w_in_ready;
    avscd_capture #(
        .COORD_BITS (COORD_BITS)
    ) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_acc),
        .i_item      (i_in.payload),
        .i_time_step (r_time_step),
        .o_done      (w_done),
        .o_now       (w_cap_now),
        .o_prev      (w_cap_prev)
    );

    // agent chain
    assign w_load_data = {i_in.payload.agent_id, w_cap_now, w_cap_prev};
    for (genvar k = 0; k < MAX_AGENTS; k++) begin : g_cell
        avscd_cell #(
            .DATA_W (DATA_W),
            .CNT_W  (CNT_W),
            .POS    (k),
            .LAST   (MAX_AGENTS - 1)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_count     (r_count),
            .i_load_data (w_load_data),
            .i_next_data (w_cell_q[(k < MAX_AGENTS - 1) ? k + 1 : k]),
            .i_head_data (w_cell_q[0]),
            .o_data      (w_cell_q[k])
        );
    end

    // pair compare: probe against the chain head
    assign w_pr_id   = r_probe[DATA_W-1 -: ID_W];
    assign w_pr_now  = r_probe[2*CW-1 -: CW];
    assign w_pr_prev = r_probe[CW-1:0];
    assign w_hd_id   = w_cell_q[0][DATA_W-1 -: ID_W];
    assign w_hd_now  = w_cell_q[0][2*CW-1 -: CW];
    assign w_hd_prev = w_cell_q[0][CW-1:0];
    assign w_vertex  = (w_pr_now == w_hd_now);
    assign w_edge    = (r_time_step != '0) && (w_pr_prev == w_hd_now)
                       && (w_hd_prev == w_pr_now);
    assign w_hit     = w_vertex || w_edge;

    // result items
    always_comb begin
        w_rec           = '0;
        w_rec.is_record = 1'b1;
        w_rec.agent_a   = w_pr_id;
        w_rec.agent_b   = w_hd_id;
        w_rec.is_edge   = !w_vertex;
        w_rec.here_x    = IO_W'($signed(w_pr_now[CW-1 -: COORD_BITS]));
        w_rec.here_y    = IO_W'($signed(w_pr_now[2*COORD_BITS-1 -: COORD_BITS]));
        w_rec.here_z    = IO_W'($signed(w_pr_now[COORD_BITS-1:0]));
        if (!w_vertex) begin
            w_rec.before_x = IO_W'($signed(w_pr_prev[CW-1 -: COORD_BITS]));
            w_rec.before_y = IO_W'($signed(w_pr_prev[2*COORD_BITS-1 -: COORD_BITS]));
            w_rec.before_z = IO_W'($signed(w_pr_prev[COORD_BITS-1:0]));
        end
        w_mark          = '0;
        w_mark.overflow = r_dropped;
        w_mark.last     = 1'b1;
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and controls
    always_comb begin
        n_state    = r_state;
        w_op       = '0;
        w_in_ready = 1'b0;
        w_probe_ld = 1'b0;
        w_out_ld   = 1'b0;
        w_mark_ld  = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                w_in_ready = 1'b1;
                if (w_in_acc && w_done) begin
                    w_op.load = (r_count < CNT_W'(MAX_AGENTS));
                end
                if (w_in_acc && i_in.payload.end_of_set) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                if (r_count <= CNT_W'(1)) begin
                    n_state = ST_MARK;
                end else begin
                    w_op.pop   = 1'b1;
                    w_probe_ld = 1'b1;
                    n_state    = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!w_hit || w_out_free) begin
                    w_op.rotate = 1'b1;
                    w_out_ld    = w_hit;
                    if (r_j == r_count - CNT_W'(1)) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_MARK: begin
                if (w_out_free) begin
                    w_mark_ld = 1'b1;
                    n_state   = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // agent count, pair index and drop flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_j       <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (w_in_acc && w_done) begin
                if (w_op.load) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (w_op.pop) begin
                r_count <= r_count - CNT_W'(1);
                r_j     <= '0;
            end
            if (w_op.rotate) begin
                r_j <= r_j + CNT_W'(1);
            end
            if (w_mark_ld) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // probe register
    always_ff @(posedge i_clk) begin
        if (w_probe_ld) begin
            r_probe <= w_cell_q[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld || w_mark_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out <= w_rec;
        end else if (w_mark_ld) begin
            r_out <= w_mark;
        end
    end

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

>>> src/avscd_checker.sv
// ----------------------------------------------------------------------------
// avscd_checker
// Port-level checks of the agent conflict detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "agent_vertex_swap_conflict_detect_assert.svh"

module avscd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_eos,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input avscd_pkg::t_out_item i_out_item
);
    import avscd_pkg::*;

    // a stalled result item holds its contents
    `AVSCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))

    // the last agent of a set starts the sweep, which holds off input
    `AVSCD_ASSERT_NEXT(a_sweep_stall, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_eos, !i_in_ready)

    // records never close a run
    `AVSCD_ASSERT_SAME(a_rec_open, i_clk, i_rst_n, i_out_valid && i_out_item.is_record, !i_out_item.last && !i_out_item.overflow)

    // the end marker carries no pair
    `AVSCD_ASSERT_SAME(a_mark_clean, i_clk, i_rst_n, i_out_valid && !i_out_item.is_record, i_out_item.last && (i_out_item.agent_a == '0) && (i_out_item.agent_b == '0) && !i_out_item.is_edge)

    // vertex records have no previous cell
    `AVSCD_ASSERT_SAME(a_vertex_before, i_clk, i_rst_n, i_out_valid && i_out_item.is_record && !i_out_item.is_edge, (i_out_item.before_x == '0) && (i_out_item.before_y == '0) && (i_out_item.before_z == '0))

endmodule

bind agent_vertex_swap_conflict_detect avscd_checker u_avscd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_eos    (i_in.payload.end_of_set),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.payload)
);

>>> test/agent_vertex_swap_conflict_detect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agent_vertex_swap_conflict_detect_tb
// Streams agent paths into the conflict detector and checks every conflict
// record and end marker against a cycle-free model of the pair sweep.
// A directed table, then random agent sets under several idle and stall
// mixes on the path and result channels, with step writes in between.
// ----------------------------------------------------------------------------
module agent_vertex_swap_conflict_detect_tb;
    import avscd_pkg::*;

    localparam int MAX_AG      = MAX_AGENTS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 80;

    typedef struct packed {
        logic signed [IO_W-1:0] x;
        logic signed [IO_W-1:0] y;
        logic signed [IO_W-1:0] z;
    } grid_cell_t;

    typedef struct {
        bit          set_step;
        logic [15:0] step;
        t_in_item    item_in;
        bit          typed;
        t_out_item   want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    avscd_chan_if #(.T(t_in_item))  in_if  ();
    avscd_chan_if #(.T(t_out_item)) out_if ();
    avscd_chan_if #(.T(t_cfg_item)) cfg_if ();

    agent_vertex_swap_conflict_detect dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the detector state
    logic [15:0] obs_step = '0;
    logic [15:0] ag_id [MAX_AG];
    grid_cell_t  ag_now [MAX_AG];
    grid_cell_t  ag_prev [MAX_AG];
    int          stored_n = 0;
    logic [15:0] path_pos = '0;
    grid_cell_t  first_cell = '0;
    grid_cell_t  cap_now = '0;
    grid_cell_t  cap_prev = '0;
    bit          cap_now_ok = 1'b0;
    bit          cap_prev_ok = 1'b0;
    bit          dropped = 1'b0;

    t_out_item   conflicts_due [$];

    // directed table and its typed results
    dir_row_t    dir_rows [$];
    bit          table_says = 1'b0;
    t_out_item   table_result;

    // run bookkeeping
    int errors = 0;
    int cells_sent = 0;
    int results_seen = 0;
    int vertex_seen = 0;
    int swap_seen = 0;
    int marker_seen = 0;
    int dropped_seen = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic void forget_path();
        path_pos    = '0;
        first_cell  = '0;
        cap_now     = '0;
        cap_prev    = '0;
        cap_now_ok  = 1'b0;
        cap_prev_ok = 1'b0;
    endfunction

    // one accepted path cell: capture, store the agent, sweep at set end
    function automatic void absorb_path_cell(input t_in_item it);
        grid_cell_t c;
        grid_cell_t nowc;
        grid_cell_t prevc;
        t_out_item  r;
        c.x = it.cell_x;
        c.y = it.cell_y;
        c.z = it.cell_z;
        if (!it.path_empty) begin
            if (path_pos == 16'd0) first_cell = c;
            if (!cap_now_ok && path_pos == obs_step) begin
                cap_now = c;
                cap_now_ok = 1'b1;
            end
            if (obs_step != 16'd0 && !cap_prev_ok && path_pos == obs_step - 16'd1) begin
                cap_prev = c;
                cap_prev_ok = 1'b1;
            end
            if (path_pos != 16'hFFFF) path_pos = path_pos + 16'd1;
        end
        if (it.path_empty || it.end_of_path || it.end_of_set) begin
            if (it.path_empty) begin
                nowc  = '0;
                prevc = '0;
            end else begin
                nowc = cap_now_ok ? cap_now : c;
                if (obs_step == 16'd0) prevc = first_cell;
                else prevc = cap_prev_ok ? cap_prev : c;
            end
            if (stored_n < MAX_AG) begin
                ag_id[stored_n]   = it.agent_id;
                ag_now[stored_n]  = nowc;
                ag_prev[stored_n] = prevc;
                stored_n++;
            end else begin
                dropped = 1'b1;
            end
            forget_path();
        end
        if (it.end_of_set) begin
            // every pair in arrival order
            for (int i = 0; i < stored_n; i++) begin
                for (int j = i + 1; j < stored_n; j++) begin
                    r = '0;
                    if (ag_now[i] == ag_now[j]) begin
                        r.is_record = 1'b1;
                    end else if (obs_step != 16'd0 && ag_prev[i] == ag_now[j]
                                 && ag_prev[j] == ag_now[i]) begin
                        r.is_record = 1'b1;
                        r.is_edge   = 1'b1;
                        r.before_x  = ag_prev[i].x;
                        r.before_y  = ag_prev[i].y;
                        r.before_z  = ag_prev[i].z;
                    end
                    if (r.is_record) begin
                        r.agent_a = ag_id[i];
                        r.agent_b = ag_id[j];
                        r.here_x  = ag_now[i].x;
                        r.here_y  = ag_now[i].y;
                        r.here_z  = ag_now[i].z;
                        conflicts_due.push_back(r);
                    end
                end
            end
            r = '0;
            r.overflow = dropped;
            r.last     = 1'b1;
            conflicts_due.push_back(r);
            stored_n = 0;
            dropped  = 1'b0;
            forget_path();
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: result %0d field %s expected %h got %h",
                     $time, results_seen, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (conflicts_due.size() == 0) begin
            $display("%0t: result %0d not expected, got %h", $time, results_seen, got);
            errors++;
        end else begin
            want = conflicts_due.pop_front();
            cmp_field("is_record", 16'(want.is_record), 16'(got.is_record));
            cmp_field("agent_a", want.agent_a, got.agent_a);
            cmp_field("agent_b", want.agent_b, got.agent_b);
            cmp_field("is_edge", 16'(want.is_edge), 16'(got.is_edge));
            cmp_field("here_x", want.here_x, got.here_x);
            cmp_field("here_y", want.here_y, got.here_y);
            cmp_field("here_z", want.here_z, got.here_z);
            cmp_field("before_x", want.before_x, got.before_x);
            cmp_field("before_y", want.before_y, got.before_y);
            cmp_field("before_z", want.before_z, got.before_z);
            cmp_field("overflow", 16'(want.overflow), 16'(got.overflow));
            cmp_field("last", 16'(want.last), 16'(got.last));
        end
        if (!got.is_record) begin
            marker_seen++;
            if (got.overflow) dropped_seen++;
        end else if (got.is_edge) begin
            swap_seen++;
        end else begin
            vertex_seen++;
        end
        results_seen++;
    endfunction

    // handshake monitor, prediction, checking and watchdog
    always @(posedge i_clk) begin
        int base;
        bit moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                obs_step = cfg_if.payload.time_step;
                moved = 1'b1;
            end
            if (in_if.valid && in_if.ready) begin
                base = conflicts_due.size();
                absorb_path_cell(in_if.payload);
                if (table_says) begin
                    if (conflicts_due.size() > base) conflicts_due[base] = table_result;
                    else conflicts_due.push_back(table_result);
                end
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                check_result(out_if.payload);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result receiver with random stalls
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic grid_cell_t rand_cell();
        logic [15:0] v [3];
        grid_cell_t c;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 11))
                0:       v[k] = 16'h8000;
                1:       v[k] = 16'h7FFF;
                2:       v[k] = 16'h0000;
                3:       v[k] = 16'hFFFF;
                default: v[k] = 16'($urandom);
            endcase
        end
        c.x = v[0];
        c.y = v[1];
        c.z = v[2];
        return c;
    endfunction

    function automatic t_in_item make_item(input logic [15:0] id, input grid_cell_t c,
                                           input bit emp, input bit eop, input bit eos);
        t_in_item it;
        it.agent_id    = id;
        it.cell_x      = c.x;
        it.cell_y      = c.y;
        it.cell_z      = c.z;
        it.path_empty  = emp;
        it.end_of_path = eop;
        it.end_of_set  = eos;
        return it;
    endfunction

    function automatic void add_row(input bit ss, input logic [15:0] st,
                                    input logic [15:0] id, input logic [15:0] x,
                                    input logic [15:0] y, input logic [15:0] z,
                                    input bit emp, input bit eop, input bit eos,
                                    input bit typ, input t_out_item w);
        dir_row_t   row;
        grid_cell_t c;
        c.x = x;
        c.y = y;
        c.z = z;
        row.set_step = ss;
        row.step     = st;
        row.item_in  = make_item(id, c, emp, eop, eos);
        row.typed    = typ;
        row.want     = w;
        dir_rows.push_back(row);
    endfunction

    // path cell sender, called and returning on a falling edge
    task automatic put_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // step write once the detector has drained
    task automatic write_step(input logic [15:0] step);
        in_if.valid <= 1'b0;
        while (conflicts_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.payload.time_step <= step;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // well-formed agent set drawn from a small pool of shared cells
    task automatic send_agent_set();
        grid_cell_t pool [3];
        grid_cell_t path [5];
        grid_cell_t last_path [5];
        grid_cell_t tmp;
        int pool_n;
        int n_ag;
        int plen;
        int last_len;
        int s;
        bit open_end;
        bit is_last;
        logic [15:0] id;
        pool_n = $urandom_range(1, 3);
        for (int k = 0; k < 3; k++) pool[k] = rand_cell();
        n_ag = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
        open_end = ($urandom_range(0, 2) == 0);
        last_len = 0;
        for (int a = 0; a < n_ag; a++) begin
            id = 16'($urandom);
            is_last = (a == n_ag - 1);
            if ($urandom_range(0, 9) == 0) begin
                // empty path, maybe after a few cells that get discarded
                plen = $urandom_range(0, 2);
                for (int k = 0; k < plen; k++)
                    put_item(make_item(id, pool[$urandom_range(0, pool_n - 1)], 0, 0, 0));
                put_item(make_item(id, rand_cell(), 1, 1'($urandom_range(0, 1)), is_last));
                last_len = 0;
            end else begin
                if (last_len > 0 && $urandom_range(0, 3) == 0) begin
                    // swap the observed step and the one before of the last agent
                    plen = last_len;
                    path = last_path;
                    s = int'(obs_step);
                    if (s != 0 && s < plen) begin
                        tmp         = path[s];
                        path[s]     = path[s - 1];
                        path[s - 1] = tmp;
                    end
                end else begin
                    plen = $urandom_range(1, 5);
                    for (int k = 0; k < plen; k++)
                        path[k] = ($urandom_range(0, 99) < 85) ?
                                  pool[$urandom_range(0, pool_n - 1)] : rand_cell();
                end
                for (int k = 0; k < plen; k++)
                    put_item(make_item(id, path[k], 0,
                                       k == plen - 1 && !(is_last && open_end),
                                       k == plen - 1 && is_last));
                last_path = path;
                last_len  = plen;
            end
        end
    endtask

    initial begin
        t_out_item  end_clean;
        t_out_item  end_dropped;
        t_out_item  blank_res;
        logic [15:0] st;

        in_if.valid    <= 1'b0;
        in_if.payload  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        i_rst_n        <= 1'b0;

        blank_res = '0;
        end_clean = '0;
        end_clean.last = 1'b1;
        end_dropped = end_clean;
        end_dropped.overflow = 1'b1;

        // lone empty path right after reset
        add_row(0, 0, 16'h0000, 16'h1111, 16'h2222, 16'h3333, 1, 0, 1, 1, end_clean);
        // vertex conflict at the coordinate extremes
        add_row(0, 0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 0, 1, 0, 0, blank_res);
        add_row(0, 0, 16'h1234, 16'h7FFF, 16'h8000, 16'hFFFF, 0, 1, 1, 1,
                t_out_item'{1'b1, 16'hFFFF, 16'h1234, 1'b0, 16'h7FFF, 16'h8000, 16'hFFFF,
                            16'h0, 16'h0, 16'h0, 1'b0, 1'b0});
        // empty path discards earlier cells and sits at the origin
        add_row(0, 0, 16'h0005, 16'h0003, 16'h0003, 16'h0003, 0, 0, 0, 0, blank_res);
        add_row(0, 0, 16'h0005, 16'h0001, 16'h0002, 16'h0003, 1, 0, 0, 0, blank_res);
        add_row(0, 0, 16'h0006, 16'h0000, 16'h0000, 16'h0000, 0, 1, 1, 1,
                t_out_item'{1'b1, 16'h0005, 16'h0006, 1'b0, 16'h0, 16'h0, 16'h0,
                            16'h0, 16'h0, 16'h0, 1'b0, 1'b0});
        // swap at step 1, set end without path end
        add_row(1, 1, 16'h000A, 16'h0001, 16'h0000, 16'h0000, 0, 0, 0, 0, blank_res);
        add_row(0, 0, 16'h000A, 16'h0002, 16'h0000, 16'h0000, 0, 1, 0, 0, blank_res);
        add_row(0, 0, 16'h000B, 16'h0002, 16'h0000, 16'h0000, 0, 0, 0, 0, blank_res);
        add_row(0, 0, 16'h000B, 16'h0001, 16'h0000, 16'h0000, 0, 0, 1, 1,
                t_out_item'{1'b1, 16'h000A, 16'h000B, 1'b1, 16'h0002, 16'h0000, 16'h0000,
                            16'h0001, 16'h0000, 16'h0000, 1'b0, 1'b0});
        // one agent past capacity
        for (int k = 1; k <= MAX_AG + 1; k++)
            add_row(0, 0, 16'(16'h30 + k), 16'(k), 16'(k), 16'(k), 0, 1,
                    k == MAX_AG + 1, k == MAX_AG + 1, end_dropped);
        // step changed in the middle of a set
        add_row(0, 0, 16'h0014, 16'h0005, 16'h0005, 16'h0005, 0, 0, 0, 0, blank_res);
        add_row(0, 0, 16'h0014, 16'h0006, 16'h0006, 16'h0006, 0, 1, 0, 0, blank_res);
        add_row(1, 0, 16'h0015, 16'h0006, 16'h0006, 16'h0006, 0, 1, 1, 0, blank_res);
        // largest step, far past the end of both paths
        add_row(1, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 0, 0, blank_res);
        add_row(0, 0, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 1, 0, blank_res);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_step) write_step(dir_rows[r].step);
            table_says   = dir_rows[r].typed;
            table_result = dir_rows[r].want;
            put_item(dir_rows[r].item_in);
            table_says   = 1'b0;
        end

        // random sets under each idle and stall mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (int base = cells_sent; cells_sent - base < PHASE_ITEMS; ) begin
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: st = 16'd0;
                        3, 4, 5: st = 16'd1;
                        6, 7:    st = 16'($urandom_range(2, 4));
                        8:       st = 16'($urandom);
                        default: st = 16'hFFFF;
                    endcase
                    write_step(st);
                end
                if ($urandom_range(0, 6) == 0) begin
                    // noise: arbitrary flags, may leave a set open
                    repeat ($urandom_range(1, 6))
                        put_item(make_item(16'($urandom), rand_cell(),
                                           $urandom_range(0, 5) == 0,
                                           $urandom_range(0, 2) == 0,
                                           $urandom_range(0, 5) == 0));
                end else begin
                    send_agent_set();
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // drain and let the detector settle
        in_if.valid <= 1'b0;
        while (conflicts_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Sent %0d path cells over %0d agent sets, %0d of them past capacity.",
                 cells_sent, marker_seen, dropped_seen);
        $display("Saw %0d vertex and %0d swap conflicts at steps from 0 to 65535.",
                 vertex_seen, swap_seen);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
